// File: hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared definitions for the stream find-and-replace block
// Sizes, configuration register codes and the command word handed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned MaxSearch  = 8;
  localparam int unsigned MaxReplace = 8;
  localparam int unsigned LenW       = 4;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;

  // One command carries at most the larger of a replacement or a flushed window.
  localparam int unsigned CmdBytes  = (MaxSearch > MaxReplace) ? MaxSearch : MaxReplace;
  localparam int unsigned CntW      = $clog2(CmdBytes + 1);
  localparam int unsigned IdxW      = (CmdBytes > 1) ? $clog2(CmdBytes) : 1;
  localparam int unsigned PendDepth = (MaxSearch > 1) ? MaxSearch - 1 : 1;
  localparam int unsigned PcW       = (MaxSearch > 1) ? $clog2(MaxSearch) : 1;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgSearchPattern = 3'd0,
    CfgSearchLength  = 3'd1,
    CfgReplaceText   = 3'd2,
    CfgReplaceLength = 3'd3
  } cfg_idx_e;

  // cnt == 0 with last set is a bare end marker
  typedef struct packed {
    logic [CmdBytes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                cnt;
    logic                           last;
  } cmd_t;

endpackage

// File: hw/rtl/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr_text_if / sfr_result_if: valid-ready channels of the block
// Text words in, rewritten result words out.
// ----------------------------------------------------------------------------
interface sfr_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sfr_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       last_out;

  modport source (output valid, output out_byte, output byte_present, output last_out,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_present, input last_out,
                  output ready);
endinterface

// File: hw/rtl/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace: streaming find-and-replace over a text stream
// Replaces each leftmost non-overlapping occurrence of the search pattern by
// the replacement text; all other words pass in order.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  txt_i     in   valid / ready        text_byte[7:0], end_of_text
//  res_o     out  valid / ready        out_byte[7:0], byte_present, last_out
//  cfg       in   cfg_we_i (no wait)   cfg_idx_i[2:0], cfg_data_i[63:0]
//
//  One text word a cycle in while txt_i.ready is high; the back end sends one
//  result word a cycle unless res_o.ready or an empty queue holds it. A word
//  that completes a match hands the back end the whole replacement, a final
//  word that misses up to the pattern length of window bytes; the two-entry
//  queue takes up the difference and txt_i.ready drops only when it is full.
//  Reset clears configuration, window and control state, but not the queue
//  storage or the output data registers; no clearing pass. An accepted word
//  reaches its first result word via a queue entry, then the output register.
//
module stream_find_replace import sfr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  sfr_text_if.sink            txt_i,
  sfr_result_if.source        res_o
);

  // front end -> queue
  cmd_t fe_cmd;
  logic fe_valid, fe_ready;
  // queue -> back end
  cmd_t hd_cmd;
  logic hd_valid, hd_pop;

  // window, match compare and configuration registers
  sfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .txt         (txt_i),
    .cmd_o       (fe_cmd),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready)
  );

  // lets the front keep taking words while a burst drains
  sfr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cmd_i   (fe_cmd),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .rd_cmd_o   (hd_cmd),
    .rd_valid_o (hd_valid),
    .rd_pop_i   (hd_pop)
  );

  // serialises commands, owns the output register
  sfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (hd_cmd),
    .cmd_valid_i (hd_valid),
    .cmd_pop_o   (hd_pop),
    .res         (res_o)
  );

endmodule

// File: hw/rtl/sfr_front.sv
// ----------------------------------------------------------------------------
// sfr_front: configuration registers and match window
// Takes one text word per cycle while the queue has room, updates the pending
// window and issues one command per word that produces output.
// ----------------------------------------------------------------------------
module sfr_front import sfr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  sfr_text_if.sink            txt,
  output cmd_t                cmd_o,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i
);

  logic [MaxSearch-1:0][ByteW-1:0]  pat_q;
  logic [MaxReplace-1:0][ByteW-1:0] rep_q;
  logic [LenW-1:0]                  slen_q, rlen_q;
  logic [PendDepth-1:0][ByteW-1:0]  pend_q, pend_d;
  logic [PcW-1:0]                   pc_q, pc_d;

  logic [LenW-1:0]                  slen, rlen, newcnt;
  logic [PcW-1:0]                   pc_eff;
  logic [MaxSearch-1:0][ByteW-1:0]  win;
  logic                             full, hit, accept;

  always_comb begin
    slen = (slen_q > LenW'(MaxSearch)) ? LenW'(MaxSearch) : slen_q;
    rlen = (rlen_q > LenW'(MaxReplace)) ? LenW'(MaxReplace) : rlen_q;
    pc_eff = (LenW'(pc_q) >= slen) ? '0 : pc_q;

    win = '0;
    for (int i = 0; i < PendDepth; i++) begin
      win[i] = pend_q[i];
    end
    win[pc_eff] = txt.text_byte;
    newcnt = LenW'(pc_eff) + LenW'(1);
    full   = (newcnt == slen);

    hit = 1'b1;
    for (int i = 0; i < MaxSearch; i++) begin
      if ((LenW'(i) < slen) && (win[i] != pat_q[i])) begin
        hit = 1'b0;
      end
    end

    cmd_o       = '0;
    cmd_o.last  = txt.end_of_text;
    pc_d        = pc_q;
    pend_d      = pend_q;
    if (slen == '0) begin
      // pass through
      cmd_o.bytes[0] = txt.text_byte;
      cmd_o.cnt      = CntW'(1);
    end else if (full && hit) begin
      for (int i = 0; i < MaxReplace; i++) begin
        cmd_o.bytes[i] = rep_q[i];
      end
      cmd_o.cnt = CntW'(rlen);
      pc_d      = '0;
    end else if (txt.end_of_text) begin
      // flush the whole window, oldest first
      for (int i = 0; i < MaxSearch; i++) begin
        cmd_o.bytes[i] = win[i];
      end
      cmd_o.cnt = CntW'(newcnt);
      pc_d      = '0;
    end else if (full) begin
      cmd_o.bytes[0] = win[0];
      cmd_o.cnt      = CntW'(1);
      for (int i = 0; i < PendDepth; i++) begin
        pend_d[i] = win[i+1];
      end
      pc_d = PcW'(slen - LenW'(1));
    end else begin
      for (int i = 0; i < PendDepth; i++) begin
        pend_d[i] = win[i];
      end
      pc_d = PcW'(newcnt);
    end
  end

  // words that only grow the window need no command
  assign cmd_valid_o = txt.valid && ((cmd_o.cnt != '0) || txt.end_of_text);
  assign txt.ready   = cmd_ready_i;
  assign accept      = txt.valid && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      rep_q  <= '0;
      slen_q <= '0;
      rlen_q <= '0;
      pc_q   <= '0;
      pend_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgSearchPattern: pat_q <= cfg_data_i[MaxSearch*ByteW-1:0];
        CfgSearchLength: begin
          slen_q <= cfg_data_i[LenW-1:0];
          pc_q   <= '0;
        end
        CfgReplaceText:   rep_q  <= cfg_data_i[MaxReplace*ByteW-1:0];
        CfgReplaceLength: rlen_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end else if (accept) begin
      pc_q   <= pc_d;
      pend_q <= pend_d;
    end
  end

endmodule

// File: hw/rtl/sfr_queue.sv
// ----------------------------------------------------------------------------
// sfr_queue: two-entry command queue
// Decouples the front end from output stalls.
// ----------------------------------------------------------------------------
module sfr_queue import sfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t wr_cmd_i,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  output cmd_t rd_cmd_o,
  output logic rd_valid_o,
  input  logic rd_pop_i
);

  cmd_t [QDepth-1:0] mem_q;
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;
  logic              push, pop;

  assign wr_ready_o = (cnt_q != QCntW'(QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_cmd_o   = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

// File: hw/rtl/sfr_back.sv
// ----------------------------------------------------------------------------
// sfr_back: command serialiser; walks the head command one word per cycle
// into the output register while the receiver does not stall it.
// ----------------------------------------------------------------------------
module sfr_back import sfr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  sfr_result_if.source  res
);

  logic [IdxW-1:0]  idx_q;
  logic             vld_q;
  logic [ByteW-1:0] byte_q;
  logic             pres_q, last_q;
  logic             load, final_w, marker;

  assign load    = cmd_valid_i && (!vld_q || res.ready);
  assign marker  = (cmd_i.cnt == '0);
  assign final_w = marker || ((CntW'(idx_q) + CntW'(1)) == cmd_i.cnt);
  assign cmd_pop_o = load && final_w;

  assign res.valid        = vld_q;
  assign res.out_byte     = byte_q;
  assign res.byte_present = pres_q;
  assign res.last_out     = last_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= marker ? '0 : cmd_i.bytes[idx_q];
      pres_q <= !marker;
      last_q <= final_w && cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        idx_q <= final_w ? '0 : idx_q + IdxW'(1);
      end else if (res.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

endmodule

// File: bench/stream_find_replace_tb.sv
// ----------------------------------------------------------------------------
// stream_find_replace_tb: self-checking bench for the stream find-and-replace
// Drives text words into the block under random idling and back-pressure. A
// behavioural copy of the rewrite rules predicts every result word, and each
// word that leaves the block is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module stream_find_replace_tb import sfr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       last_out;
  } rewrite_word_t;

  localparam int unsigned LongHold = 300;   // receiver hold-off, in cycles

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  sfr_text_if   txt ();
  sfr_result_if res ();

  stream_find_replace uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .txt_i      (txt),
    .res_o      (res)
  );

  // Words waiting to be offered, and rewritten words still owed by the block
  text_word_t    text_q[$];
  rewrite_word_t rewritten_q[$];

  // Shadow copy of the configuration and the held (unmatched) bytes
  logic [63:0] srch_pat;
  logic [3:0]  srch_len;
  logic [63:0] rep_txt;
  logic [3:0]  rep_len;
  logic [7:0]  held [MaxSearch];
  int unsigned held_cnt;

  // Idling knobs, set per phase; percentages of offered words (sender) and of ready cycles (receiver) that start a gap
  int unsigned tx_gap_pct;
  int unsigned rx_stall_pct;
  int unsigned tx_gap_left;
  int unsigned rx_stall_left;
  bit          hold_req;
  bit          long_hold;

  int unsigned err_cnt;
  int unsigned words_sent;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Prediction: one accepted text word in, its rewritten words appended
  // --------------------------------------------------------------------------
  function automatic void rewrite_step(input logic [7:0] b, input logic eot);
    rewrite_word_t batch [MaxSearch + MaxReplace];
    int unsigned   sl, rl, n, i;
    bit            hit;
    // lengths beyond the maximum saturate
    sl = (srch_len > MaxSearch) ? MaxSearch : srch_len;
    rl = (rep_len > MaxReplace) ? MaxReplace : rep_len;
    n  = 0;
    if (sl == 0) begin
      // empty pattern: straight through
      batch[n] = '{b, 1'b1, 1'b0};
      n++;
    end else begin
      if (held_cnt >= sl) held_cnt = 0;
      held[held_cnt] = b;
      held_cnt++;
      if (held_cnt == sl) begin
        hit = 1'b1;
        for (i = 0; i < sl; i++)
          if (held[i] != srch_pat[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          // full window matched: replacement out, window cleared
          for (i = 0; i < rl; i++) begin
            batch[n] = '{rep_txt[8*i +: 8], 1'b1, 1'b0};
            n++;
          end
          held_cnt = 0;
        end else begin
          // no match: only the oldest byte leaves, the rest slide down
          batch[n] = '{held[0], 1'b1, 1'b0};
          n++;
          for (i = 1; i < sl; i++) held[i-1] = held[i];
          held_cnt = sl - 1;
        end
      end
      if (eot) begin
        // end of text flushes whatever is still held
        for (i = 0; i < held_cnt; i++) begin
          batch[n] = '{held[i], 1'b1, 1'b0};
          n++;
        end
        held_cnt = 0;
      end
    end
    if (eot) begin
      // nothing to carry the last flag: bare end marker
      if (n == 0) begin
        batch[0] = '{8'h00, 1'b0, 1'b0};
        n = 1;
      end
      batch[n-1].last_out = 1'b1;
    end
    for (i = 0; i < n; i++) rewritten_q.push_back(batch[i]);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    return ($urandom_range(99) < 85) ? $urandom_range(3, 1) : $urandom_range(30, 8);
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < 50) $display("tb: MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Text driver: offers queued words, holds each until accepted
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : text_driver
    text_word_t nxt;
    if (rst_ni) begin
      if (txt.valid && txt.ready) rewrite_step(txt.text_byte, txt.end_of_text);
      if (!txt.valid || txt.ready) begin
        if (tx_gap_left != 0) begin
          tx_gap_left--;
          txt.valid <= 1'b0;
        end else if (text_q.size() != 0) begin
          nxt = text_q.pop_front();
          txt.valid       <= 1'b1;
          txt.text_byte   <= nxt.text_byte;
          txt.end_of_text <= nxt.end_of_text;
          // gap taken after this word is accepted
          if ($urandom_range(99) < tx_gap_pct) tx_gap_left = gap_len();
        end else begin
          txt.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each accepted word, then decides ready
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : res_monitor
    rewrite_word_t want;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        if (rewritten_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %02h present %0b last %0b",
                                    res.out_byte, res.byte_present, res.last_out));
        end else begin
          want = rewritten_q.pop_front();
          if (res.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte got %02h want %02h",
                                      res.out_byte, want.out_byte));
          if (res.byte_present !== want.byte_present)
            report_mismatch($sformatf("byte_present got %0b want %0b",
                                      res.byte_present, want.byte_present));
          if (res.last_out !== want.last_out)
            report_mismatch($sformatf("last_out got %0b want %0b",
                                      res.last_out, want.last_out));
        end
      end
      if (long_hold) begin
        res.ready <= 1'b0;
      end else if (rx_stall_left != 0) begin
        rx_stall_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        if ($urandom_range(99) < rx_stall_pct) rx_stall_left = gap_len();
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering meanwhile
  initial begin : recv_hold
    wait (hold_req);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (LongHold) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // Run limit, well beyond the slowest correct run
  initial begin : run_limit
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Waits until every queued word is taken and every result has arrived,
  // then lets the clock run on since a held word produces nothing to wait for
  task automatic wait_idle();
    do @(negedge clk_i);
    while (text_q.size() != 0 || txt.valid || rewritten_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Register write; only called while the block is idle
  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CfgSearchPattern: srch_pat = val;
      CfgSearchLength: begin
        srch_len = val[3:0];
        held_cnt = 0;          // new length drops the held bytes
      end
      CfgReplaceText:   rep_txt = val;
      CfgReplaceLength: rep_len = val[3:0];
      default: ;
    endcase
  endtask

  // n bytes of s, first byte lowest; eot on the last one if asked
  task automatic send_bytes(input logic [63:0] s, input int unsigned n, input bit eot);
    int unsigned i;
    @(negedge clk_i);
    for (i = 0; i < n; i++)
      text_q.push_back('{s[8*i +: 8], (eot && i == n - 1)});
  endtask

  // Random text of roughly len words, built mostly from the pattern so that
  // matches, near misses and overlaps are frequent
  task automatic send_text(input int unsigned len, input bit pause_mid);
    text_word_t  words[$];
    text_word_t  w;
    int unsigned eff, r, k, cut;
    logic [7:0]  b;
    eff = (srch_len > MaxSearch) ? MaxSearch : srch_len;
    while (words.size() < len) begin
      r = $urandom_range(99);
      if (r < 35 && eff != 0) begin
        // whole pattern, one time in four with one byte corrupted
        cut = ($urandom_range(3) == 0) ? $urandom_range(eff - 1) : eff;
        for (k = 0; k < eff; k++) begin
          b = srch_pat[8*k +: 8];
          if (k == cut) b = b ^ (8'd1 << $urandom_range(7));
          words.push_back('{b, 1'b0});
        end
      end else if (r < 70) begin
        words.push_back('{srch_pat[8*$urandom_range(7) +: 8], 1'b0});
      end else begin
        words.push_back('{8'($urandom), 1'b0});
      end
    end
    w = words.pop_back();
    w.end_of_text = 1'b1;
    words.push_back(w);
    @(negedge clk_i);
    foreach (words[i]) begin
      // sender pauses halfway until the block has caught up
      if (pause_mid && i == words.size() / 2) wait_idle();
      text_q.push_back(words[i]);
    end
    words_sent += words.size();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [63:0] pat, rtx;
    logic [3:0]  sl, rl;
    int unsigned phase, t, n_texts;

    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CfgSearchPattern;
    cfg_data        = '0;
    txt.valid       = 1'b0;
    txt.text_byte   = 8'h00;
    txt.end_of_text = 1'b0;
    res.ready       = 1'b0;
    srch_pat        = '0;
    srch_len        = '0;
    rep_txt         = '0;
    rep_len         = '0;
    held_cnt        = 0;
    foreach (held[i]) held[i] = 8'h00;
    tx_gap_pct      = 0;
    rx_stall_pct    = 0;
    tx_gap_left     = 0;
    rx_stall_left   = 0;
    hold_req        = 1'b0;
    long_hold       = 1'b0;
    err_cnt         = 0;
    words_sent      = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed ---
    // reset configuration: empty pattern, extreme byte values pass through
    send_bytes(64'hFF00, 2, 1'b1);
    wait_idle();

    // "ab" -> "XYZ": match, miss then match, lone byte flushed at the end
    write_reg(CfgSearchPattern, 64'h6261);
    write_reg(CfgSearchLength, 64'd2);
    write_reg(CfgReplaceText, 64'h5A5958);
    write_reg(CfgReplaceLength, 64'd3);
    send_bytes(64'h616261616261, 6, 1'b1);
    wait_idle();

    // empty replacement swallowing the whole text: bare end marker
    write_reg(CfgReplaceLength, 64'd0);
    send_bytes(64'h6261, 2, 1'b1);
    wait_idle();

    // search length rewritten mid-text drops the held 'a'
    send_bytes(64'h61, 1, 1'b0);
    wait_idle();
    write_reg(CfgSearchLength, 64'd2);
    send_bytes(64'h62, 1, 1'b1);
    wait_idle();

    // replacement rewritten mid-text: held 'a' kept, new text used
    write_reg(CfgReplaceLength, 64'd3);
    send_bytes(64'h61, 1, 1'b0);
    wait_idle();
    write_reg(CfgReplaceText, 64'h333231);
    send_bytes(64'h62, 1, 1'b1);
    wait_idle();

    // oversized lengths saturate; junk above the length field is ignored
    write_reg(CfgSearchPattern, 64'h0);
    write_reg(CfgSearchLength, 64'hFFFF_FFFF_FFFF_FFF9);
    write_reg(CfgReplaceText, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CfgReplaceLength, 64'hF);
    send_bytes(64'h0, 8, 1'b1);
    wait_idle();

    // --- random phases ---
    words_sent = 0;
    phase      = 0;
    while (words_sent < 220) begin
      wait_idle();
      pat = {$urandom, $urandom};
      rtx = {$urandom, $urandom};
      case (phase % 8)
        0: begin sl = 4'd1; rl = 4'd8; end
        1: begin sl = 4'd8; rl = 4'd0; end
        2: begin sl = 4'd0; rl = 4'($urandom_range(8)); end
        3: begin sl = 4'd3; rl = 4'd2; end
        4: begin sl = 4'($urandom_range(15, 9)); rl = 4'($urandom_range(15, 9)); end
        5: begin sl = 4'($urandom_range(8, 1)); rl = 4'($urandom_range(8)); end
        6: begin
          // one repeated byte: overlapping candidates, leftmost must win
          pat = {8{8'($urandom)}};
          sl  = 4'd2;
          rl  = 4'd1;
        end
        default: begin sl = 4'($urandom_range(8, 1)); rl = 4'($urandom_range(15)); end
      endcase
      write_reg(CfgSearchPattern, pat);
      write_reg(CfgSearchLength, {32'($urandom), 28'd0, sl});
      write_reg(CfgReplaceText, rtx);
      write_reg(CfgReplaceLength, {60'd0, rl});

      // first phase runs flat out, later ones idle at random rates
      if (phase == 0) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_pct   = 20 * $urandom_range(3);
        rx_stall_pct = 20 * $urandom_range(3);
      end

      // receiver holds off while a long text keeps coming: input must stall
      if (phase == 3) begin
        hold_req = 1'b1;
        send_text(40, 1'b0);
      end

      n_texts = $urandom_range(3, 1);
      for (t = 0; t < n_texts; t++)
        send_text(($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1),
                  (phase == 5 && t == 0) || $urandom_range(9) == 0);
      phase++;
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (rewritten_q.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", rewritten_q.size()));
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
